@@ sv/api_pkg.sv @@
`timescale 1ns / 1ps

package api_pkg;

	localparam int CORDIC_STEPS = 24;

	// 2^32 / (2 pi) as Q0.32
	localparam logic [63:0] TWO_PI_RECIP = 64'd683565276;
	// CORDIC start vector length (inverse gain), Q2.30
	localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

	localparam logic signed [31:0] Q32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;      // two's complement, sign at bit nbits-1
		logic [6:0]  nbits;
	} mul_req_t;

	// arctangent of 2^-i in binary angle units
	function automatic logic signed [33:0] atan_brad(input logic [4:0] i);
		logic signed [33:0] v;
		unique case (i)
			5'd0:  v = 34'sd536870912;
			5'd1:  v = 34'sd316933406;
			5'd2:  v = 34'sd167458907;
			5'd3:  v = 34'sd85004756;
			5'd4:  v = 34'sd42667331;
			5'd5:  v = 34'sd21354465;
			5'd6:  v = 34'sd10680862;
			5'd7:  v = 34'sd5340245;
			5'd8:  v = 34'sd2670163;
			5'd9:  v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			5'd24: v = 34'sd41;
			5'd25: v = 34'sd20;
			5'd26: v = 34'sd10;
			5'd27: v = 34'sd5;
			5'd28: v = 34'sd3;
			5'd29: v = 34'sd1;
			5'd30: v = 34'sd1;
			5'd31: v = 34'sd0;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/api_mul.sv @@
`timescale 1ns / 1ps

// Bit-serial signed multiplier, one multiplier bit per cycle, result mod 2^64.
module api_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  api_pkg::mul_req_t  req,
	output logic               done,
	output logic [63:0]        prod
);

	logic [63:0] a_q, b_q, acc_q;
	logic [6:0]  cnt_q, nbits_q;
	logic        busy_q, done_q;
	logic [63:0] addend;
	logic        last;

	assign addend = b_q[0] ? a_q : 64'd0;
	assign last   = (cnt_q == nbits_q - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q     <= req.a;
			b_q     <= req.b;
			nbits_q <= req.nbits;
			acc_q   <= 64'd0;
			cnt_q   <= 7'd0;
		end else if (busy_q) begin
			// sign bit carries negative weight
			acc_q <= last ? acc_q - addend : acc_q + addend;
			a_q   <= {a_q[62:0], 1'b0};
			b_q   <= {1'b0, b_q[63:1]};
			cnt_q <= cnt_q + 7'd1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ sv/api_cordic.sv @@
`timescale 1ns / 1ps

// Rotation-mode CORDIC, one micro-rotation per cycle.
module api_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         angle,
	output logic                done,
	output logic signed [33:0]  cos_o,
	output logic signed [33:0]  sin_o
);

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic               flip_q, busy_q, done_q;
	logic               flip;
	logic [31:0]        r, a_plus;
	logic               last;
	logic signed [33:0] xs, ys, at;

	assign a_plus = angle + 32'h4000_0000;
	assign flip   = a_plus[31];
	assign r      = flip ? angle + 32'h8000_0000 : angle;
	assign last   = ({1'b0, i_q} == 6'(api_pkg::CORDIC_STEPS - 1));
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign at     = api_pkg::atan_brad(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= api_pkg::CORDIC_START;
			y_q    <= 34'sd0;
			z_q    <= {{2{r[31]}}, r};
			i_q    <= 5'd0;
			flip_q <= flip;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			i_q <= i_q + 5'd1;
		end
	end

	assign done  = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

endmodule

@@ sv/arc_pose_integrator.sv @@
`timescale 1ns / 1ps

// arc_pose_integrator: planar unicycle odometry along the exact arc.
// Input stream (s_*): one request per control tick with speed, yaw rate and
// elapsed time. Output stream (m_*): one result per request with the updated
// pose (x, y, binary-angle heading) and a saturation flag in m_tuser.
// One tick is processed at a time; s_tready is high only while the sequencer
// is idle. Each tick runs through a shared bit-serial multiplier and a shared
// CORDIC: a turning tick takes the yaw*time product, the angle scaling, a
// CORDIC run on the old heading, the radius division, a CORDIC run on the
// new heading and two 35-bit products; a straight tick takes one CORDIC run
// and a speed*time product in place of the division and second CORDIC.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a finished tick holds in the last state
// until the output register frees up, and the pose commits at that moment.
// Reset (arst_n low) clears the pose to origin, heading zero, drops m_tvalid.
module arc_pose_integrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // speed[23:0], yaw_rate[47:24], elapsed[67:48], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading[95:64]
	output logic        m_tuser    // overflow
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MP   = 4'd1;  // p = yaw_rate * elapsed
	localparam logic [3:0] ST_MK   = 4'd2;  // heading step = p * 2^32/(2 pi)
	localparam logic [3:0] ST_C0   = 4'd3;  // sin/cos of old heading
	localparam logic [3:0] ST_VT   = 4'd4;  // straight distance
	localparam logic [3:0] ST_DIV  = 4'd5;  // arc radius
	localparam logic [3:0] ST_C1   = 4'd6;  // sin/cos of new heading
	localparam logic [3:0] ST_DX   = 4'd7;
	localparam logic [3:0] ST_DY   = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] state_q;
	logic       issued_q;

	// tick operands
	logic signed [23:0] v_q, w_q;
	logic [19:0]        t_q;
	logic               wz_q;

	// pose
	logic signed [31:0] px_q, py_q;
	logic [31:0]        hd_q, h1_q;

	// intermediates
	logic [63:0]        p_q;
	logic signed [33:0] c0_q, s0_q, c1_q, s1_q;
	logic signed [31:0] rad_q;
	logic signed [33:0] dx_q, dy_q;
	logic               sat_q;

	// radius divider
	logic [23:0] rem_q;
	logic [39:0] quo_q;
	logic [5:0]  dcnt_q;
	logic [23:0] wabs;
	logic [39:0] nabs;
	logic [24:0] trial;
	logic        trial_ok;
	logic        qneg;
	logic signed [40:0] qs;

	// shared units
	api_pkg::mul_req_t  mreq;
	logic               mdone;
	logic [63:0]        mprod;
	logic               cstart, cdone;
	logic signed [33:0] ccos, csin;

	logic               mul_state;
	logic signed [34:0] bx, by, bsel;
	logic signed [34:0] sumx, sumy;
	logic signed [31:0] nx, ny;
	logic               ovx, ovy;

	api_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mdone),
		.prod   (mprod)
	);

	api_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.angle  ((state_q == ST_C1) ? h1_q : hd_q),
		.done   (cdone),
		.cos_o  (ccos),
		.sin_o  (csin)
	);

	assign s_tready = (state_q == ST_IDLE);

	// multiplier operand select
	assign bx   = wz_q ? {c0_q[33], c0_q} : {s1_q[33], s1_q} - {s0_q[33], s0_q};
	assign by   = wz_q ? {s0_q[33], s0_q} : {c0_q[33], c0_q} - {c1_q[33], c1_q};
	assign bsel = (state_q == ST_DX) ? bx : by;
	assign mul_state = (state_q == ST_MP) || (state_q == ST_MK) || (state_q == ST_VT) ||
		(state_q == ST_DX) || (state_q == ST_DY);

	always_comb begin
		mreq       = '0;
		mreq.start = mul_state && !issued_q;
		unique case (state_q)
			ST_MP: begin
				mreq.a     = {{40{w_q[23]}}, w_q};
				mreq.b     = {44'd0, t_q};
				mreq.nbits = 7'd21;
			end
			ST_MK: begin
				mreq.a     = p_q;
				mreq.b     = api_pkg::TWO_PI_RECIP;
				mreq.nbits = 7'd31;
			end
			ST_VT: begin
				mreq.a     = {{40{v_q[23]}}, v_q};
				mreq.b     = {44'd0, t_q};
				mreq.nbits = 7'd21;
			end
			ST_DX, ST_DY: begin
				mreq.a     = {{32{rad_q[31]}}, rad_q};
				mreq.b     = {{29{bsel[34]}}, bsel};
				mreq.nbits = 7'd35;
			end
			default: begin
				mreq.a     = 64'd0;
				mreq.b     = 64'd0;
				mreq.nbits = 7'd0;
			end
		endcase
	end

	assign cstart = ((state_q == ST_C0) || (state_q == ST_C1)) && !issued_q;

	// radius: (speed * 2^16) / yaw_rate, truncated, on magnitudes
	assign wabs     = w_q[23] ? 24'(-w_q) : 24'(w_q);
	assign nabs     = v_q[23] ? 40'(-{v_q, 16'd0}) : {v_q, 16'd0};
	assign trial    = {rem_q, quo_q[39]} - {1'b0, wabs};
	assign trial_ok = !trial[24];
	assign qneg     = v_q[23] ^ w_q[23];
	assign qs       = qneg ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// position update with saturation
	assign sumx = {{3{px_q[31]}}, px_q} + {dx_q[33], dx_q};
	assign sumy = {{3{py_q[31]}}, py_q} + {dy_q[33], dy_q};
	assign ovx  = (sumx > 35'(api_pkg::Q32_MAX)) || (sumx < 35'(api_pkg::Q32_MIN));
	assign ovy  = (sumy > 35'(api_pkg::Q32_MAX)) || (sumy < 35'(api_pkg::Q32_MIN));
	assign nx   = ovx ? (sumx[34] ? api_pkg::Q32_MIN : api_pkg::Q32_MAX) : sumx[31:0];
	assign ny   = ovy ? (sumy[34] ? api_pkg::Q32_MIN : api_pkg::Q32_MAX) : sumy[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			m_tvalid <= 1'b0;
			px_q     <= 32'sd0;
			py_q     <= 32'sd0;
			hd_q     <= 32'd0;
		end else begin
			// the output state sets m_tvalid itself
			if (m_tvalid && m_tready && (state_q != ST_OUT))
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MP;
					end
				end
				ST_MP, ST_MK, ST_VT, ST_DX, ST_DY, ST_C0, ST_C1: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (mdone || cdone) begin
						issued_q <= 1'b0;
						unique case (state_q)
							ST_MP:   state_q <= ST_MK;
							ST_MK:   state_q <= ST_C0;
							ST_C0:   state_q <= wz_q ? ST_VT : ST_DIV;
							ST_VT:   state_q <= ST_DX;
							ST_C1:   state_q <= ST_DX;
							ST_DX:   state_q <= ST_DY;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_DIV: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (dcnt_q == 6'd40) begin
						issued_q <= 1'b0;
						state_q  <= ST_C1;
					end
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						px_q     <= nx;
						py_q     <= ny;
						hd_q     <= h1_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					v_q   <= s_tdata[23:0];
					w_q   <= s_tdata[47:24];
					t_q   <= s_tdata[67:48];
					wz_q  <= (s_tdata[47:24] == 24'd0);
					sat_q <= 1'b0;
				end
			end
			ST_MP: if (issued_q && mdone) p_q <= mprod;
			ST_MK: if (issued_q && mdone) h1_q <= hd_q + mprod[63:32];
			ST_C0: begin
				if (issued_q && cdone) begin
					c0_q <= ccos;
					s0_q <= csin;
				end
			end
			ST_C1: begin
				if (issued_q && cdone) begin
					c1_q <= ccos;
					s1_q <= csin;
				end
			end
			ST_VT: begin
				// floor(speed*elapsed / 2^16)
				if (issued_q && mdone) rad_q <= {{4{mprod[43]}}, mprod[43:16]};
			end
			ST_DIV: begin
				if (!issued_q) begin
					rem_q  <= 24'd0;
					quo_q  <= nabs;
					dcnt_q <= 6'd0;
				end else if (dcnt_q != 6'd40) begin
					rem_q  <= trial_ok ? trial[23:0] : {rem_q[22:0], quo_q[39]};
					quo_q  <= {quo_q[38:0], trial_ok};
					dcnt_q <= dcnt_q + 6'd1;
				end else begin
					if (qs > 41'(api_pkg::Q32_MAX)) begin
						rad_q <= api_pkg::Q32_MAX;
						sat_q <= 1'b1;
					end else if (qs < 41'(api_pkg::Q32_MIN)) begin
						rad_q <= api_pkg::Q32_MIN;
						sat_q <= 1'b1;
					end else begin
						rad_q <= qs[31:0];
					end
				end
			end
			ST_DX: if (issued_q && mdone) dx_q <= mprod[63:30];
			ST_DY: if (issued_q && mdone) dy_q <= mprod[63:30];
			ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {h1_q, ny, nx};
					m_tuser <= sat_q | ovx | ovy;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ tb/pose_checker.sv @@
`timescale 1ns / 1ps

module pose_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hd;
		logic        ovf;
	} pose_t;

	pose_t       pose_q[$];
	logic [31:0] x_pos, y_pos, head;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip32(longint v, ref bit sat);
		if (v > longint'(api_pkg::Q32_MAX)) begin
			sat = 1;
			return longint'(api_pkg::Q32_MAX);
		end
		if (v < longint'(api_pkg::Q32_MIN)) begin
			sat = 1;
			return longint'(api_pkg::Q32_MIN);
		end
		return v;
	endfunction

	// CORDIC rotation, results Q2.30
	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		logic [31:0] r;
		bit          flip;
		longint      z, xv, yv, xs, ys;
		flip = (ang + 32'h4000_0000) >> 31;
		r = flip ? ang + 32'h8000_0000 : ang;
		z = longint'($signed(r));
		xv = longint'(api_pkg::CORDIC_START);
		yv = 0;
		for (int i = 0; i < api_pkg::CORDIC_STEPS && i < 32; i++) begin
			xs = fshr(xv, i);
			ys = fshr(yv, i);
			if (z >= 0) begin
				xv -= ys; yv += xs; z -= longint'(api_pkg::atan_brad(i[4:0]));
			end else begin
				xv += ys; yv -= xs; z += longint'(api_pkg::atan_brad(i[4:0]));
			end
		end
		c = flip ? -xv : xv;
		s = flip ? -yv : yv;
	endtask

	task automatic advance_pose(input logic [71:0] d);
		longint      v, w, t, px, py, c0, s0, c1, s1, dx, dy, travel, rad;
		logic [63:0] p, prod;
		logic [31:0] h1;
		bit          sat;
		pose_t       e;
		v = longint'($signed(d[23:0]));
		w = longint'($signed(d[47:24]));
		t = longint'(d[67:48]);
		sat = 0;
		px = longint'($signed(x_pos));
		py = longint'($signed(y_pos));
		p = w * t;
		prod = p * api_pkg::TWO_PI_RECIP;
		h1 = head + prod[63:32];
		rotate(head, c0, s0);
		if (w == 0) begin
			travel = fshr(v * t, 16);
			dx = fshr(travel * c0, 30);
			dy = fshr(travel * s0, 30);
		end else begin
			rad = clip32((v * 65536) / w, sat);
			rotate(h1, c1, s1);
			dx = fshr(rad * (s1 - s0), 30);
			dy = fshr(rad * (c0 - c1), 30);
		end
		px = clip32(px + dx, sat);
		py = clip32(py + dy, sat);
		x_pos = px[31:0];
		y_pos = py[31:0];
		head = h1;
		e.x = x_pos; e.y = y_pos; e.hd = head; e.ovf = sat;
		pose_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_t e;
		if (!arst_n) begin
			x_pos = '0;
			y_pos = '0;
			head = '0;
			pose_q.delete();
			fail_count <= 0;
		end else begin
			// result side first: its expectation was queued on an earlier edge
			if (m_tvalid && m_tready) begin
				if (pose_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h ovf %b", m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					e = pose_q.pop_front();
					if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y
							|| m_tdata[95:64] !== e.hd || m_tuser !== e.ovf) begin
						if (fail_count < 10)
							$display("pose mismatch: exp x=%h y=%h h=%h ovf=%b got x=%h y=%h h=%h ovf=%b",
								e.x, e.y, e.hd, e.ovf, m_tdata[31:0], m_tdata[63:32],
								m_tdata[95:64], m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				advance_pose(s_tdata);
		end
	end

	assign pending = pose_q.size();

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // speed[23:0], yaw_rate[47:24], elapsed[67:48], zero pad
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [95:0] m_tdata;        // pos_x[31:0], pos_y[63:32], heading[95:64]
	logic        m_tuser;        // overflow
	int          fail_count;
	int          pending;
	int unsigned cycles = 0;

	// covers the slowest (turning) tick plus sender gaps and receiver stalls
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	always #5 clk = ~clk;

	arc_pose_integrator u_dut (.*);

	pose_checker u_chk (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// receiver: random stalls, with quiet stretches of always-ready
	initial begin
		int stall;
		bit calm;
		@(posedge arst_n);
		forever begin
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(20, 200)) begin
				stall = calm ? 0 : gap_len();
				if (stall > 0) begin
					m_tready <= 0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_tick(input logic [23:0] spd, input logic [23:0] yaw,
			input logic [19:0] dt);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'd0, dt, yaw, spd};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [23:0] pick24();
		case ($urandom_range(0, 5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'd0;
			3: return $urandom_range(0, 2047) - 1024;   // slow, near zero
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [19:0] pick_dt();
		case ($urandom_range(0, 5))
			0: return 20'hfffff;
			1: return 20'd0;
			2: return $urandom_range(1, 200);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [23:0] spd, yaw;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: straight, arcs, extremes, zero time, radius saturation
		send_tick(24'h010000, 24'd0, 20'h10000);
		send_tick(24'h7fffff, 24'd0, 20'hfffff);
		send_tick(24'h800000, 24'd0, 20'hfffff);
		send_tick(24'h010000, 24'h010000, 20'h10000);
		send_tick(24'h010000, 24'hff0000, 20'h08000);
		send_tick(24'h7fffff, 24'd1, 20'h00010);      // radius saturates
		send_tick(24'h800000, 24'hffffff, 20'h00010);
		send_tick(24'h7fffff, 24'd1, 20'd0);          // zero time, still overflow
		send_tick(24'h123456, 24'h7fffff, 20'd0);
		send_tick(24'h7fffff, 24'h7fffff, 20'hfffff);
		send_tick(24'h800000, 24'h800000, 20'hfffff);
		send_tick(24'h7fffff, 24'h800000, 20'h7ffff);
		send_tick(24'd0, 24'h3243f, 20'h10000);
		for (int i = 0; i < 8; i++)
			send_tick(24'h7fffff, 24'd0, 20'hfffff);   // drive toward position saturation
		for (int i = 0; i < 4; i++)
			send_tick(24'h7fffff, 24'd2, 20'hfffff);

		// hold off until the block drains
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int n = 0; n < 2000; n++) begin
			spd = pick24();
			yaw = ($urandom_range(0, 3) == 0) ? 24'd0 : pick24();
			send_tick(spd, yaw, pick_dt());
		end
		s_tvalid <= 0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
